// File: hdl/ps2_frame_receiver_fifo_core_macros.svh
// Assertion macros for the checker file of the PS/2 receiver.
`ifndef PS2_FRAME_RECEIVER_FIFO_CORE_MACROS_SVH
`define PS2_FRAME_RECEIVER_FIFO_CORE_MACROS_SVH

// Concurrent assertion on the rising clock, off while reset is high.
`define PS2RX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the rising clock that also holds during reset.
`define PS2RX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ps2rx_pkg.sv
// Types, constants and helpers of the PS/2 frame receiver.
`default_nettype none
package ps2rx_pkg;

  localparam int FIFO_DEPTH_DEF = 16;
  localparam int FRAME_W        = 11;
  localparam int CODE_W         = 8;
  localparam int FILL_W         = 4;
  localparam int GAP_W          = 8;
  localparam int BCNT_W         = 4;

  localparam logic [GAP_W-1:0]  GAP_LIMIT_RST = 8'd5;
  localparam logic [GAP_W-1:0]  GAP_MAX       = 8'hFF;
  localparam logic [FILL_W-1:0] FILL_MAX      = 4'd15;
  localparam logic [BCNT_W-1:0] FRAME_LEN     = 4'(FRAME_W);

  typedef enum logic [1:0] {
    KIND_EDGE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_POP  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CODE_W-1:0] popped_code;
    logic              popped_valid;
    logic              frame_stored;
    logic              frame_dropped;
    logic [FILL_W-1:0] fill_level;
  } res_t;

  // Data bits arrive LSB first, so data bit 0 sits highest in the shifted frame.
  function automatic logic [CODE_W-1:0] frame_data(input logic [FRAME_W-2:0] f);
    logic [CODE_W-1:0] b;
    for (int i = 0; i < CODE_W; i++) begin
      b[i] = f[FRAME_W-2-i];
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// File: hdl/ps2_frame_receiver_fifo_core.sv
// PS/2 device-to-host frame receiver with a ring FIFO of received bytes.
// Each result is registered in the output buffer, or in the skid buffer on out_stall.
// Throughput: one request per cycle while in_stall is low; a two-deep output buffer
// keeps input moving for one more request while a result waits on out_stall.
// Reset clears the frame shifter, gap counter, FIFO pointers and buffer valid flags,
// and sets gap_limit to 5; the byte store needs no clearing pass.
`default_nettype none
module ps2_frame_receiver_fifo_core #(
  parameter int FIFO_DEPTH = ps2rx_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [ps2rx_pkg::GAP_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic [1:0]                  kind,
  input  wire logic                        data_bit,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [ps2rx_pkg::CODE_W-1:0] popped_code,
  output      logic                        popped_valid,
  output      logic                        frame_stored,
  output      logic                        frame_dropped,
  output      logic [ps2rx_pkg::FILL_W-1:0] fill_level
);
  import ps2rx_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;
  localparam int RES_LOW_W = $bits(res_t) - CODE_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [GAP_W-1:0]    gap_limit;
  logic [FRAME_W-2:0]  frame_bits, frame_bits_next;
  logic [BCNT_W-1:0]   bit_count, bit_count_next;
  logic [GAP_W-1:0]    gap_ticks, gap_ticks_next;
  logic [PTR_W-1:0]    read_slot, read_slot_next;
  logic [PTR_W-1:0]    write_slot, write_slot_next;
  logic [CODE_W-1:0]   byte_store [FIFO_DEPTH];

  logic                out_valid_q, skid_valid;
  res_t                out_res, skid_res, new_res;

  logic                accept, out_free;
  logic                gap_clear, frame_done, fifo_full, do_store, pop_ok;
  logic [FRAME_W-2:0]  base_bits, frame_shift;
  logic [BCNT_W-1:0]   base_count, count_inc;
  logic [PTR_W-1:0]    write_inc, read_inc;
  logic [CNT_W-1:0]    held;
  logic [CNT_W+3:0]    held_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid & ~skid_valid;
  assign out_free  = ~out_valid_q | ~out_stall;

  assign write_inc = (write_slot == PTR_LAST) ? '0 : write_slot + PTR_W'(1);
  assign read_inc  = (read_slot == PTR_LAST) ? '0 : read_slot + PTR_W'(1);

  always_comb begin
    gap_clear   = gap_ticks > gap_limit;
    base_bits   = gap_clear ? '0 : frame_bits;
    base_count  = gap_clear ? '0 : bit_count;
    frame_shift = {base_bits[FRAME_W-3:0], data_bit};
    count_inc   = base_count + BCNT_W'(1);
    frame_done  = count_inc >= FRAME_LEN;
    fifo_full   = write_inc == read_slot;

    frame_bits_next  = frame_bits;
    bit_count_next   = bit_count;
    gap_ticks_next   = gap_ticks;
    read_slot_next   = read_slot;
    write_slot_next  = write_slot;
    do_store         = 1'b0;
    pop_ok           = 1'b0;
    new_res          = '0;

    case (kind_t'(kind))
      KIND_EDGE: begin
        gap_ticks_next = '0;
        if (frame_done) begin
          frame_bits_next = '0;
          bit_count_next  = '0;
          if (fifo_full) begin
            new_res.frame_dropped = 1'b1;
          end else begin
            do_store             = 1'b1;
            write_slot_next      = write_inc;
            new_res.frame_stored = 1'b1;
          end
        end else begin
          frame_bits_next = frame_shift;
          bit_count_next  = count_inc;
        end
      end
      KIND_TICK: begin
        if (gap_ticks != GAP_MAX) begin
          gap_ticks_next = gap_ticks + GAP_W'(1);
        end
      end
      KIND_POP: begin
        if (read_slot != write_slot) begin
          pop_ok               = 1'b1;
          read_slot_next       = read_inc;
          new_res.popped_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Bytes held after this request, with the ring wrap folded in.
    if (write_slot_next >= read_slot_next) begin
      held = {1'b0, write_slot_next} - {1'b0, read_slot_next};
    end else begin
      held = CNT_W'(FIFO_DEPTH) - {1'b0, read_slot_next} + {1'b0, write_slot_next};
    end
    held_ext = {4'b0, held};
    new_res.fill_level = (held_ext > (CNT_W+4)'(FILL_MAX)) ? FILL_MAX : held_ext[FILL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit   <= GAP_LIMIT_RST;
      frame_bits  <= '0;
      bit_count   <= '0;
      gap_ticks   <= '0;
      read_slot   <= '0;
      write_slot  <= '0;
      out_valid_q <= 1'b0;
      skid_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        gap_limit <= cfg_data;
      end
      if (accept) begin
        frame_bits <= frame_bits_next;
        bit_count  <= bit_count_next;
        gap_ticks  <= gap_ticks_next;
        read_slot  <= read_slot_next;
        write_slot <= write_slot_next;
      end
      if (out_free) begin
        out_valid_q <= skid_valid | accept;
        skid_valid  <= 1'b0;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Byte store and result buffers; the popped byte is read straight into
  // whichever buffer takes the new result.
  always_ff @(posedge clk) begin
    if (accept && do_store) begin
      byte_store[write_slot] <= frame_data(frame_shift);
    end
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= {pop_ok ? byte_store[read_slot] : new_res.popped_code,
                    new_res[RES_LOW_W-1:0]};
      end
    end else if (accept) begin
      skid_res <= {pop_ok ? byte_store[read_slot] : new_res.popped_code,
                   new_res[RES_LOW_W-1:0]};
    end
  end

  assign out_valid     = out_valid_q;
  assign popped_code   = out_res.popped_code;
  assign popped_valid  = out_res.popped_valid;
  assign frame_stored  = out_res.frame_stored;
  assign frame_dropped = out_res.frame_dropped;
  assign fill_level    = out_res.fill_level;

endmodule
`default_nettype wire

// File: hdl/ps2rx_checker.sv
// Port-level checker for the PS/2 frame receiver and its bind.
`default_nettype none
`include "ps2_frame_receiver_fifo_core_macros.svh"
module ps2rx_checker #(
  parameter int FIFO_DEPTH = ps2rx_pkg::FIFO_DEPTH_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [ps2rx_pkg::CODE_W-1:0] popped_code,
  input wire logic                         popped_valid,
  input wire logic                         frame_stored,
  input wire logic                         frame_dropped,
  input wire logic [ps2rx_pkg::FILL_W-1:0] fill_level
);
  import ps2rx_pkg::*;

  // A full FIFO holds one entry less than its depth, capped by the fill field.
  localparam logic [FILL_W-1:0] FILL_FULL =
    (FIFO_DEPTH - 1 > 15) ? FILL_MAX : FILL_W'(FIFO_DEPTH - 1);

  `PS2RX_ASSERT(a_code_zero, out_valid && !popped_valid |-> popped_code == '0, "popped_code set without a popped byte")
  `PS2RX_ASSERT(a_one_event, out_valid |-> $countones({popped_valid, frame_stored, frame_dropped}) <= 1, "more than one event flag in a result")
  `PS2RX_ASSERT(a_drop_full, out_valid && frame_dropped |-> fill_level == FILL_FULL, "frame dropped while the FIFO was not full")
  `PS2RX_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(popped_code) && $stable(fill_level), "stalled result changed")

endmodule

bind ps2_frame_receiver_fifo_core ps2rx_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_ps2rx_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .popped_code   (popped_code),
  .popped_valid  (popped_valid),
  .frame_stored  (frame_stored),
  .frame_dropped (frame_dropped),
  .fill_level    (fill_level)
);
`default_nettype wire
